FILE: rtl/tlrc_pkg.sv
package tlrc_pkg;

    localparam int HASH_BITS = 22;
    localparam int WIN_LEN   = 32;
    localparam int LEN_BITS  = 24;
    localparam int WIN_AW    = $clog2(WIN_LEN);
    localparam int WARM_W    = $clog2(WIN_LEN + 1);
    localparam int MASK_W    = 5;
    localparam int CFG_IDX_W = 3;

    typedef logic [HASH_BITS-1:0] t_hash;
    typedef logic [LEN_BITS-1:0]  t_len;
    typedef logic [LEN_BITS:0]    t_total;
    typedef logic [WIN_AW-1:0]    t_wptr;
    typedef logic [WARM_W-1:0]    t_warm;

    localparam t_hash  HASH_MULT = t_hash'(587);
    localparam t_hash  CUT_VALUE = '0;
    localparam t_total LEN_MAX   = t_total'((64'd1 << LEN_BITS) - 64'd1);

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_BITS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHUNK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEG   = 3'd4;

    // 587^WIN_LEN mod 2^HASH_BITS, weight of the byte leaving the window
    function automatic t_hash f_base_pow();
        longint unsigned p;
        longint unsigned m;
        p = 1;
        m = (64'd1 << HASH_BITS) - 64'd1;
        for (int i = 0; i < WIN_LEN; i++) begin
            p = (p * 64'd587) & m;
        end
        return t_hash'(p);
    endfunction

    localparam t_hash BASE_POW = f_base_pow();

    typedef struct packed {
        logic [MASK_W-1:0] mask_bits;
        t_len              min_chunk;
        t_len              max_chunk;
        t_len              min_seg;
        t_len              max_seg;
    } t_cfg;

    typedef struct packed {
        t_len offset;
        t_len length;
        logic seg_end;
        logic stream_end;
    } t_result;

endpackage

FILE: rtl/two_level_rabin_chunker_unit.sv
// A result word is registered and is on the master side in the cycle after the byte that closes the chunk.
// Throughput: one byte per cycle; the hash and cut decision are combinational for each byte and the
// window memory is read one byte ahead, so only output backpressure stalls the input.
// After reset and after each stream end, the first 32 bytes fill the window and cut nothing.
// Reset (synchronous, active low) clears control state and loads register defaults; window memory
// contents are not cleared. Both ready outputs stay low while reset is held.
module two_level_rabin_chunker_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // slave side
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [7:0]                           i_s_axis_tdata,   // [7:0] data_byte
    input  logic                                 i_s_axis_tlast,   // last_byte
    // master side
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [47:0]                          o_m_axis_tdata,   // [23:0] chunk_offset,
                                                                   // [47:24] chunk_length
    output logic                                 o_m_axis_tuser,   // closes_segment
    output logic                                 o_m_axis_tlast,   // ends_stream
    // config write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [tlrc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tlrc_pkg::LEN_BITS-1:0]        i_cfg_data
);
    import tlrc_pkg::*;

    t_cfg       r_cfg;
    logic       w_free;
    logic       w_acc;
    logic       w_emit;
    logic [7:0] w_old;
    t_result    w_res;
    t_result    w_out;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mask_bits <= MASK_W'(12);
            r_cfg.min_chunk <= t_len'(1024);
            r_cfg.max_chunk <= t_len'(16384);
            r_cfg.min_seg   <= t_len'(1048576);
            r_cfg.max_seg   <= t_len'(8388608);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MASK_BITS: r_cfg.mask_bits <= i_cfg_data[MASK_W-1:0];
                CFG_MIN_CHUNK: r_cfg.min_chunk <= i_cfg_data;
                CFG_MAX_CHUNK: r_cfg.max_chunk <= i_cfg_data;
                CFG_MIN_SEG:   r_cfg.min_seg   <= i_cfg_data;
                CFG_MAX_SEG:   r_cfg.max_seg   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = w_free && i_rst_n;
    assign w_acc           = i_s_axis_tvalid && w_free && i_rst_n;

    tlrc_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_byte  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .o_old   (w_old)
    );

    tlrc_cut u_cut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_byte  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .i_old   (w_old),
        .i_cfg   (r_cfg),
        .o_emit  (w_emit),
        .o_res   (w_res)
    );

    tlrc_oreg u_oreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_acc && w_emit),
        .i_res   (w_res),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_res   (w_out),
        .o_free  (w_free)
    );

    assign o_m_axis_tdata = {w_out.length, w_out.offset};
    assign o_m_axis_tuser = w_out.seg_end;
    assign o_m_axis_tlast = w_out.stream_end;

endmodule

FILE: rtl/tlrc_window.sv
module tlrc_window (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_acc,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic [7:0] o_old
);
    import tlrc_pkg::*;

    logic [7:0] r_mem [WIN_LEN];
    logic [7:0] r_old;
    t_wptr      r_ptr;
    t_wptr      n_ptr;

    // read is issued one word ahead: the slot the next byte overwrites. Unless a stream end
    // reset the pointer, it was written WIN_LEN words back, never on the same edge.
    always_comb begin
        if (i_last || r_ptr == t_wptr'(WIN_LEN - 1)) begin
            n_ptr = '0;
        end else begin
            n_ptr = r_ptr + t_wptr'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_mem[r_ptr] <= i_byte;
            r_old        <= r_mem[n_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_acc) begin
            r_ptr <= n_ptr;
        end
    end

    assign o_old = r_old;

endmodule

FILE: rtl/tlrc_cut.sv
module tlrc_cut (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_acc,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  logic [7:0]       i_old,
    input  tlrc_pkg::t_cfg   i_cfg,
    output logic             o_emit,
    output tlrc_pkg::t_result o_res
);
    import tlrc_pkg::*;

    t_hash  r_hash,   n_hash;
    t_warm  r_warm,   n_warm;
    t_len   r_open,   n_open;
    t_len   r_closed, n_closed;

    t_hash  w_mul_v;
    t_hash  w_mul_o;
    t_hash  w_mask;
    t_len   w_open_inc;
    t_total w_total;
    t_total w_held_total;
    logic   w_warm;
    logic   w_seg_cut;
    logic   w_chunk_cut;

    assign w_warm     = (r_warm < t_warm'(WIN_LEN));
    assign w_mul_v    = r_hash * HASH_MULT;
    assign w_mul_o    = t_hash'(i_old) * BASE_POW;
    assign w_open_inc = r_open + t_len'(1);
    assign w_total    = {1'b0, r_closed} + {1'b0, w_open_inc};
    assign w_held_total = {1'b0, r_closed} + {1'b0, r_open};

    always_comb begin
        if (w_warm) begin
            n_hash = w_mul_v + t_hash'(i_byte);
        end else begin
            n_hash = w_mul_v - w_mul_o + t_hash'(i_byte);
        end
    end

    // mask widths past the hash width test the whole hash
    always_comb begin
        for (int i = 0; i < HASH_BITS; i++) begin
            w_mask[i] = (i < int'(i_cfg.mask_bits));
        end
    end

    always_comb begin
        w_seg_cut = !w_warm && !i_last &&
                    (w_total >= LEN_MAX ||
                     (w_total >= {1'b0, i_cfg.min_seg} &&
                      (n_hash == CUT_VALUE || w_total == {1'b0, i_cfg.max_seg})));
        w_chunk_cut = !w_warm && !i_last && !w_seg_cut &&
                      ((n_hash & w_mask) == CUT_VALUE || w_open_inc == i_cfg.max_chunk) &&
                      (w_open_inc >= i_cfg.min_chunk);
    end

    always_comb begin
        n_warm   = w_warm ? r_warm + t_warm'(1) : r_warm;
        n_open   = w_open_inc;
        n_closed = r_closed;
        if (i_last) begin
            n_warm   = '0;
            n_open   = '0;
            n_closed = '0;
        end else if (w_seg_cut) begin
            n_open   = '0;
            n_closed = '0;
        end else if (w_chunk_cut) begin
            n_open   = '0;
            n_closed = w_total[LEN_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash   <= '0;
            r_warm   <= '0;
            r_open   <= '0;
            r_closed <= '0;
        end else if (i_acc) begin
            r_hash   <= i_last ? t_hash'(0) : n_hash;
            r_warm   <= n_warm;
            r_open   <= n_open;
            r_closed <= n_closed;
        end
    end

    assign o_emit            = i_last || w_seg_cut || w_chunk_cut;
    assign o_res.offset      = r_closed;
    assign o_res.length      = w_open_inc;
    assign o_res.seg_end     = i_last || w_seg_cut;
    assign o_res.stream_end  = i_last;

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && i_last |=> r_warm == '0 && r_open == '0 && r_closed == '0 && r_hash == '0)
        else $error("state not cleared after stream end");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_held_total < LEN_MAX)
        else $error("segment length reached the field limit");

    a_warm_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_warm <= t_warm'(WIN_LEN))
        else $error("warm-up count overran the window");

    a_warm_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && w_warm && o_emit |-> o_res.seg_end && o_res.stream_end)
        else $error("cut taken during warm-up");

endmodule

FILE: rtl/tlrc_oreg.sv
module tlrc_oreg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tlrc_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_valid,
    output tlrc_pkg::t_result o_res,
    output logic              o_free
);
    import tlrc_pkg::*;

    logic    r_valid;
    t_result r_res;

    // free when empty or being drained this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: tb/sv/two_level_rabin_chunker_unit_tb.sv
module two_level_rabin_chunker_unit_tb;
    import tlrc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_LEN       = 400;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_ITEMS    = 285;
    localparam int NUM_PHASES     = 6;

    // index past the register list, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;

    typedef enum logic {ROW_BYTE, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        t_len                  val;
        logic [7:0]            data;
        logic                  last;
        int                    rep;
        bit                    typed;
        t_result               want;
    } t_stim_row;

    typedef struct {
        bit      typed;
        t_result want;
    } t_byte_note;

    logic                 clk;
    logic                 rst_n   = 1'b0;
    logic                 s_valid = 1'b0;
    logic [7:0]           s_data  = 8'h00;
    logic                 s_last  = 1'b0;
    logic                 m_ready = 1'b0;
    logic                 c_valid = 1'b0;
    logic [CFG_IDX_W-1:0] c_index = CFG_MASK_BITS;
    t_len                 c_data  = '0;

    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [47:0]          o_m_axis_tdata;
    logic                 o_m_axis_tuser;
    logic                 o_m_axis_tlast;
    logic                 o_cfg_ready;

    two_level_rabin_chunker_unit u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (c_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (c_index),
        .i_cfg_data      (c_data)
    );

    // chunker shadow: registers and stream state at their reset values
    logic [MASK_W-1:0] sh_mask_bits = 5'd12;
    t_len              sh_min_chunk = 24'd1024;
    t_len              sh_max_chunk = 24'd16384;
    t_len              sh_min_seg   = 24'd1048576;
    t_len              sh_max_seg   = 24'd8388608;
    logic [7:0]        win_mem [WIN_LEN];
    t_wptr             win_ptr   = '0;
    int unsigned       warm_cnt  = 0;
    t_hash             roll_hash = '0;
    t_hash             win_weight;
    int unsigned       open_len   = 0;
    int unsigned       closed_len = 0;

    t_result           pending_chunks [$];
    t_byte_note        byte_notes [$];
    t_stim_row         dir_tab [$];
    t_cfg              phase_cfg [NUM_PHASES];

    int                err_cnt     = 0;
    int                stall_cnt   = 0;
    int                tx_idle_pct = 38;
    int                rx_idle_pct = 70;
    int                hold_reqs   = 0;
    int                hold_done   = 0;
    int unsigned       stream_left = 0;
    bit                zero_run    = 1'b0;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic t_result chunk_word(bit seg_end, bit stream_end);
        t_result r;
        r.offset     = t_len'(closed_len);
        r.length     = t_len'(open_len);
        r.seg_end    = seg_end;
        r.stream_end = stream_end;
        return r;
    endfunction

    // advances the shadow by one byte; returns 1 when a chunk closes
    function automatic bit chunk_step(input logic [7:0] b, input logic last,
                                      output t_result r);
        logic [7:0]      oldest;
        bit              warming;
        int unsigned     seg_total;
        longint unsigned low_mask;
        r = '0;
        warming = (warm_cnt < WIN_LEN);
        if (warming) begin
            roll_hash = roll_hash * HASH_MULT + t_hash'(b);
            warm_cnt++;
        end else begin
            oldest = win_mem[win_ptr];
            roll_hash = roll_hash * HASH_MULT - t_hash'(oldest) * win_weight + t_hash'(b);
        end
        win_mem[win_ptr] = b;
        win_ptr++;
        open_len++;
        if (last) begin
            r = chunk_word(1'b1, 1'b1);
            win_ptr    = '0;
            warm_cnt   = 0;
            roll_hash  = '0;
            open_len   = 0;
            closed_len = 0;
            return 1'b1;
        end
        if (warming) begin
            return 1'b0;
        end
        seg_total = closed_len + open_len;
        if (seg_total >= LEN_MAX || (seg_total >= sh_min_seg &&
            (roll_hash == CUT_VALUE || seg_total == sh_max_seg))) begin
            r = chunk_word(1'b1, 1'b0);
            closed_len = 0;
            open_len   = 0;
            return 1'b1;
        end
        low_mask = (64'd1 << sh_mask_bits) - 64'd1;
        if (((longint'(roll_hash) & low_mask) == 0 || open_len == sh_max_chunk) &&
            open_len >= sh_min_chunk) begin
            r = chunk_word(1'b0, 1'b0);
            closed_len += open_len;
            open_len = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
        if (got !== want) begin
            err_cnt++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk) begin : monitor
        t_result    got;
        t_result    want;
        t_result    pred;
        t_byte_note note;
        bit         has;
        bit         moved;
        moved = 1'b0;
        if (rst_n) begin
            // drain side first: a word leaving now belongs to an earlier byte
            if (o_m_axis_tvalid && m_ready) begin
                moved = 1'b1;
                got.offset     = o_m_axis_tdata[23:0];
                got.length     = o_m_axis_tdata[47:24];
                got.seg_end    = o_m_axis_tuser;
                got.stream_end = o_m_axis_tlast;
                if (pending_chunks.size() == 0) begin
                    err_cnt++;
                    $display("%0t: expected no word, got offset %0d length %0d seg %0b end %0b",
                             $time, got.offset, got.length, got.seg_end, got.stream_end);
                end else begin
                    want = pending_chunks.pop_front();
                    check_field("chunk_offset", want.offset, got.offset);
                    check_field("chunk_length", want.length, got.length);
                    check_field("closes_segment", 24'(want.seg_end), 24'(got.seg_end));
                    check_field("ends_stream", 24'(want.stream_end), 24'(got.stream_end));
                end
            end
            if (s_valid && o_s_axis_tready) begin
                moved = 1'b1;
                note.typed = 1'b0;
                note.want  = '0;
                if (byte_notes.size() != 0) begin
                    note = byte_notes.pop_front();
                end
                has = chunk_step(s_data, s_last, pred);
                if (note.typed) begin
                    pending_chunks.push_back(note.want);
                end else if (has) begin
                    pending_chunks.push_back(pred);
                end
            end
            if (c_valid && o_cfg_ready) begin
                moved = 1'b1;
                case (c_index)
                    CFG_MASK_BITS: sh_mask_bits = c_data[MASK_W-1:0];
                    CFG_MIN_CHUNK: sh_min_chunk = c_data;
                    CFG_MAX_CHUNK: sh_max_chunk = c_data;
                    CFG_MIN_SEG:   sh_min_seg   = c_data;
                    CFG_MAX_SEG:   sh_max_seg   = c_data;
                    default: ;
                endcase
            end
        end
        stall_cnt <= moved ? 0 : stall_cnt + 1;
    end

    initial begin
        while (stall_cnt < WATCHDOG_LIMIT) @(posedge clk);
        $display("status: fail");
        $finish;
    end

    // receiver: random backpressure, plus a long hold-off when asked
    initial begin
        forever begin
            @(posedge clk);
            if (hold_reqs != hold_done) begin
                hold_done++;
                m_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
            end
            m_ready <= (rx_idle_pct == 0) || ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic push_byte(input logic [7:0] d, input logic l, input bit typed,
                             input t_result want);
        byte_notes.push_back('{typed, want});
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        s_last  <= l;
        do @(posedge clk); while (!o_s_axis_tready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_len val);
        c_valid <= 1'b1;
        c_index <= idx;
        c_data  <= val;
        do @(posedge clk); while (!o_cfg_ready);
        c_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending_chunks.size() != 0 || byte_notes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_cfg(input t_cfg cfg);
        write_reg(CFG_MASK_BITS, t_len'(cfg.mask_bits));
        write_reg(CFG_MIN_CHUNK, cfg.min_chunk);
        write_reg(CFG_MAX_CHUNK, cfg.max_chunk);
        write_reg(CFG_MIN_SEG, cfg.min_seg);
        write_reg(CFG_MAX_SEG, cfg.max_seg);
    endtask

    function automatic t_stim_row byte_row(logic [7:0] d, logic l, int rep, bit typed,
                                           t_result want);
        t_stim_row r;
        r.kind  = ROW_BYTE;
        r.idx   = CFG_MASK_BITS;
        r.val   = '0;
        r.data  = d;
        r.last  = l;
        r.rep   = rep;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic t_stim_row reg_row(logic [CFG_IDX_W-1:0] idx, t_len val);
        t_stim_row r;
        r = byte_row(8'h00, 1'b0, 0, 1'b0, '0);
        r.kind = ROW_REG;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    initial begin
        t_result    end_len1;
        t_result    end_len3;
        t_result    no_want;
        logic [7:0] d;
        logic       l;

        win_weight = 1;
        repeat (WIN_LEN) win_weight = win_weight * HASH_MULT;

        no_want  = '0;
        end_len1 = '{offset: 24'd0, length: 24'd1, seg_end: 1'b1, stream_end: 1'b1};
        end_len3 = '{offset: 24'd0, length: 24'd3, seg_end: 1'b1, stream_end: 1'b1};

        // stream ends inside warm-up, default registers
        dir_tab.push_back(byte_row(8'h00, 1'b1, 1, 1'b1, end_len1));
        dir_tab.push_back(byte_row(8'hFF, 1'b1, 1, 1'b1, end_len1));
        dir_tab.push_back(byte_row(8'h00, 1'b0, 1, 1'b0, no_want));
        dir_tab.push_back(byte_row(8'hFF, 1'b0, 1, 1'b0, no_want));
        dir_tab.push_back(byte_row(8'h80, 1'b1, 1, 1'b1, end_len3));
        // zero mask: every byte past warm-up closes a chunk; no forced closes
        dir_tab.push_back(reg_row(CFG_MASK_BITS, 24'd0));
        dir_tab.push_back(reg_row(CFG_MIN_CHUNK, 24'd1));
        dir_tab.push_back(reg_row(CFG_MAX_CHUNK, 24'd0));
        dir_tab.push_back(reg_row(CFG_MIN_SEG, 24'hFFFFFF));
        dir_tab.push_back(reg_row(CFG_MAX_SEG, 24'd0));
        dir_tab.push_back(reg_row(CFG_SPARE, 24'hFFFFFF));
        dir_tab.push_back(byte_row(8'h00, 1'b0, 32, 1'b0, no_want));
        dir_tab.push_back(byte_row(8'h00, 1'b0, 2, 1'b0, no_want));
        // all-zero window gives a zero hash: segment cut on each byte
        dir_tab.push_back(reg_row(CFG_MIN_SEG, 24'd1));
        dir_tab.push_back(reg_row(CFG_MASK_BITS, 24'd31));
        dir_tab.push_back(byte_row(8'h00, 1'b0, 2, 1'b0, no_want));
        dir_tab.push_back(byte_row(8'hFF, 1'b0, 1, 1'b0, no_want));
        dir_tab.push_back(byte_row(8'h7F, 1'b1, 1, 1'b0, no_want));

        phase_cfg[0] = '{mask_bits: 5'd3,  min_chunk: 24'd4,       max_chunk: 24'd24,
                         min_seg: 24'd60,       max_seg: 24'd200};
        phase_cfg[1] = '{mask_bits: 5'd22, min_chunk: 24'd1,       max_chunk: 24'd40,
                         min_seg: 24'hFFFFFF,   max_seg: 24'hFFFFFF};
        phase_cfg[2] = '{mask_bits: 5'd5,  min_chunk: 24'hFFFFFF,  max_chunk: 24'hFFFFFF,
                         min_seg: 24'd1,        max_seg: 24'd100};
        phase_cfg[3] = '{mask_bits: 5'd2,  min_chunk: 24'd8,       max_chunk: 24'd16,
                         min_seg: 24'd50,       max_seg: 24'd50};
        phase_cfg[4] = '{mask_bits: 5'd1,  min_chunk: 24'd2,       max_chunk: 24'd0,
                         min_seg: 24'd10,       max_seg: 24'd0};
        phase_cfg[5] = '{mask_bits: 5'd4,  min_chunk: 24'd3,       max_chunk: 24'd30,
                         min_seg: 24'd1,        max_seg: 24'd1};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_REG) begin
                wait_idle();
                write_reg(dir_tab[i].idx, dir_tab[i].val);
            end else begin
                repeat (dir_tab[i].rep) begin
                    push_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].typed,
                              dir_tab[i].want);
                end
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            case (p / 2)
                0: begin tx_idle_pct = 38; rx_idle_pct = 70; end
                1: begin tx_idle_pct = 70; rx_idle_pct = 38; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            apply_cfg(phase_cfg[p]);
            if (p == 1) begin
                hold_reqs++;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // mostly streams past warm-up; some end early, some are zero runs
                if (stream_left == 0) begin
                    stream_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 31)
                                                              : $urandom_range(33, 400);
                    zero_run = ($urandom_range(0, 4) == 0);
                end
                d = (zero_run && $urandom_range(0, 19) != 0) ? 8'h00
                                                             : 8'($urandom_range(0, 255));
                l = (stream_left == 1);
                stream_left--;
                push_byte(d, l, 1'b0, no_want);
            end
        end

        wait_idle();
        if (err_cnt == 0 && pending_chunks.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
